>>> rtl/iscd_pkg.sv
// Shared types and constants for the impedance sweep change detector.
// Holds the sequencer control-word format and the microcode program.
// Depends on nothing; imported by the top level and its checker.
package iscd_pkg;

   localparam int SQ_W    = 32;   // re^2 + im^2
   localparam int RAD_W   = 40;   // radicand, squares shifted to Q.8
   localparam int ROOT_W  = 20;   // magnitude in Q16.4
   localparam int SREM_W  = 24;   // square root partial remainder
   localparam int NUM_W   = 40;   // divider dividend / quotient
   localparam int DEN_W   = 20;   // divider divisor
   localparam int SUM_W   = 40;
   localparam int AVG_W   = 28;
   localparam int THR_W   = 10;
   localparam int SCALE_W = 32;
   localparam int PROD_W  = AVG_W + THR_W;
   localparam int OHMS_W  = SCALE_W + 4;
   localparam int CSR_W   = 32;
   localparam int IDX_W   = 3;
   localparam int PC_W    = 5;
   localparam int ITER_W  = 6;

   localparam logic [ITER_W-1:0] SQRT_STEPS = ITER_W'(ROOT_W);
   localparam logic [ITER_W-1:0] OHMS_STEPS = ITER_W'(OHMS_W);
   localparam logic [ITER_W-1:0] AVG_STEPS  = ITER_W'(NUM_W);

   // configuration register indexes
   localparam logic [IDX_W-1:0] CSR_DETECT_MODE      = 3'd0;
   localparam logic [IDX_W-1:0] CSR_IMPEDANCE_SCALE  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_THRESHOLD_STRONG = 3'd2;
   localparam logic [IDX_W-1:0] CSR_THRESHOLD_MIDDLE = 3'd3;
   localparam logic [IDX_W-1:0] CSR_THRESHOLD_WEAK   = 3'd4;

   // change levels
   localparam logic [1:0] LVL_NONE   = 2'd0;
   localparam logic [1:0] LVL_WEAK   = 2'd1;
   localparam logic [1:0] LVL_MIDDLE = 2'd2;
   localparam logic [1:0] LVL_STRONG = 2'd3;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WAIT,
      OP_SQ_RE,
      OP_SQ_IM,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_DIV_OHMS_INIT,
      OP_DIV_STEP,
      OP_ACCUM,
      OP_DIV_AVG_INIT,
      OP_AVG_SAT,
      OP_CAPTURE,
      OP_PROD,
      OP_CMP,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_ITER_MORE,
      COND_MAG_ZERO,
      COND_NOT_DONE,
      COND_BASE_VALID,
      COND_CROSSED,
      COND_RSP_BLOCKED
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [1:0]       sel;     // threshold / level select
      logic [PC_W-1:0]  target;  // jump target when cond holds
   } ctrl_word_type;

   // program step addresses
   localparam logic [PC_W-1:0] STEP_WAIT      = 5'd0;
   localparam logic [PC_W-1:0] STEP_SQ_RE     = 5'd1;
   localparam logic [PC_W-1:0] STEP_SQ_IM     = 5'd2;
   localparam logic [PC_W-1:0] STEP_SQRT_INIT = 5'd3;
   localparam logic [PC_W-1:0] STEP_SQRT_LOOP = 5'd4;
   localparam logic [PC_W-1:0] STEP_OHMS_INIT = 5'd5;
   localparam logic [PC_W-1:0] STEP_OHMS_LOOP = 5'd6;
   localparam logic [PC_W-1:0] STEP_ACCUM     = 5'd7;
   localparam logic [PC_W-1:0] STEP_AVG_INIT  = 5'd8;
   localparam logic [PC_W-1:0] STEP_AVG_LOOP  = 5'd9;
   localparam logic [PC_W-1:0] STEP_AVG_SAT   = 5'd10;
   localparam logic [PC_W-1:0] STEP_CAPTURE   = 5'd11;
   localparam logic [PC_W-1:0] STEP_PROD_S    = 5'd12;
   localparam logic [PC_W-1:0] STEP_CMP_S     = 5'd13;
   localparam logic [PC_W-1:0] STEP_PROD_M    = 5'd14;
   localparam logic [PC_W-1:0] STEP_CMP_M     = 5'd15;
   localparam logic [PC_W-1:0] STEP_PROD_W    = 5'd16;
   localparam logic [PC_W-1:0] STEP_CMP_W     = 5'd17;
   localparam logic [PC_W-1:0] STEP_EMIT      = 5'd18;
   localparam logic [PC_W-1:0] STEP_RETURN    = 5'd19;

   // microcode ROM: execute op, then jump to target if cond holds, else advance
   function automatic ctrl_word_type iscd_microcode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      unique case (pc)
         STEP_WAIT:      w = '{OP_WAIT,         COND_NO_REQ,      LVL_NONE,   STEP_WAIT};
         STEP_SQ_RE:     w = '{OP_SQ_RE,        COND_NONE,        LVL_NONE,   STEP_WAIT};
         STEP_SQ_IM:     w = '{OP_SQ_IM,        COND_NONE,        LVL_NONE,   STEP_WAIT};
         STEP_SQRT_INIT: w = '{OP_SQRT_INIT,    COND_NONE,        LVL_NONE,   STEP_WAIT};
         STEP_SQRT_LOOP: w = '{OP_SQRT_STEP,    COND_ITER_MORE,   LVL_NONE,   STEP_SQRT_LOOP};
         STEP_OHMS_INIT: w = '{OP_DIV_OHMS_INIT, COND_MAG_ZERO,   LVL_NONE,   STEP_ACCUM};
         STEP_OHMS_LOOP: w = '{OP_DIV_STEP,     COND_ITER_MORE,   LVL_NONE,   STEP_OHMS_LOOP};
         STEP_ACCUM:     w = '{OP_ACCUM,        COND_NOT_DONE,    LVL_NONE,   STEP_WAIT};
         STEP_AVG_INIT:  w = '{OP_DIV_AVG_INIT, COND_NONE,        LVL_NONE,   STEP_WAIT};
         STEP_AVG_LOOP:  w = '{OP_DIV_STEP,     COND_ITER_MORE,   LVL_NONE,   STEP_AVG_LOOP};
         STEP_AVG_SAT:   w = '{OP_AVG_SAT,      COND_BASE_VALID,  LVL_NONE,   STEP_PROD_S};
         STEP_CAPTURE:   w = '{OP_CAPTURE,      COND_ALWAYS,      LVL_NONE,   STEP_EMIT};
         STEP_PROD_S:    w = '{OP_PROD,         COND_NONE,        LVL_STRONG, STEP_WAIT};
         STEP_CMP_S:     w = '{OP_CMP,          COND_CROSSED,     LVL_STRONG, STEP_EMIT};
         STEP_PROD_M:    w = '{OP_PROD,         COND_NONE,        LVL_MIDDLE, STEP_WAIT};
         STEP_CMP_M:     w = '{OP_CMP,          COND_CROSSED,     LVL_MIDDLE, STEP_EMIT};
         STEP_PROD_W:    w = '{OP_PROD,         COND_NONE,        LVL_WEAK,   STEP_WAIT};
         STEP_CMP_W:     w = '{OP_CMP,          COND_NONE,        LVL_WEAK,   STEP_WAIT};
         STEP_EMIT:      w = '{OP_EMIT,         COND_RSP_BLOCKED, LVL_NONE,   STEP_EMIT};
         STEP_RETURN:    w = '{OP_NOP,          COND_ALWAYS,      LVL_NONE,   STEP_WAIT};
         default:        w = '{OP_NOP,          COND_ALWAYS,      LVL_NONE,   STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

>>> rtl/impedance_sweep_change_detector_unit.sv
// Sequence: a point is accepted, then runs its magnitude, divide and accumulate steps
//   before the next request is taken; a zero magnitude skips the divide.
// A sweep-ending point adds a 40-step average divide and up to six compare steps:
//   its response is registered at the emit step, which waits while the last one is held.
// One point is in work at a time: req_ready stays low until the program is back at wait.
// Reset (synchronous, active high) clears the sequencer, sums, baseline and registers.
//
// Depends on iscd_pkg (microcode ROM, control-word types, constants).
module impedance_sweep_change_detector_unit
   import iscd_pkg::*;
#(
   parameter int MAX_POINTS = 512
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [15:0]       req_real_part,
   input  logic signed [15:0]       req_imag_part,
   input  logic                     req_sweep_done,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [AVG_W-1:0]         rsp_average_ohms,
   output logic [1:0]               rsp_change_level,
   output logic [2:0]               rsp_level_flags,
   output logic                     rsp_baseline_captured,

   input  logic                     csr_wr_en,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic               detect_mode_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [THR_W-1:0]   thr_strong_ff;
   logic [THR_W-1:0]   thr_middle_ff;
   logic [THR_W-1:0]   thr_weak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_mode_ff <= 1'b1;
         scale_ff       <= 32'd208671300;
         thr_strong_ff  <= 10'd128;
         thr_middle_ff  <= 10'd166;
         thr_weak_ff    <= 10'd205;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DETECT_MODE:      detect_mode_ff <= csr_data[0];
            CSR_IMPEDANCE_SCALE:  scale_ff       <= csr_data[SCALE_W-1:0];
            CSR_THRESHOLD_STRONG: thr_strong_ff  <= csr_data[THR_W-1:0];
            CSR_THRESHOLD_MIDDLE: thr_middle_ff  <= csr_data[THR_W-1:0];
            CSR_THRESHOLD_WEAK:   thr_weak_ff    <= csr_data[THR_W-1:0];
            default: ;  // unused indexes: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;

   logic signed [15:0]  re_ff, re_in;
   logic signed [15:0]  im_ff, im_in;
   logic                done_ff, done_in;

   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W-1:0]    drem_ff, drem_in;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [AVG_W-1:0]    avg_ff, avg_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [1:0]          level_ff, level_in;
   logic                captured_ff, captured_in;
   logic [AVG_W-1:0]    baseline_ff, baseline_in;
   logic                base_valid_ff, base_valid_in;
   logic [2:0]          sticky_ff, sticky_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]    rsp_avg_ff, rsp_avg_in;
   logic [1:0]          rsp_level_ff, rsp_level_in;
   logic [2:0]          rsp_flags_ff, rsp_flags_in;
   logic                rsp_capt_ff, rsp_capt_in;

   // ---------------------------------------------------------------
   // Control word and datapath helpers
   // ---------------------------------------------------------------
   ctrl_word_type       ctrl;
   logic                req_fire;
   logic                rsp_free;
   logic                cond_hit;

   logic signed [31:0]  re_sq;
   logic signed [31:0]  im_sq;
   logic [SREM_W-1:0]   srem_shift;
   logic [SREM_W-1:0]   srem_trial;
   logic                sqrt_ge;
   logic [DEN_W:0]      drem_shift;
   logic                div_ge;
   logic [THR_W-1:0]    thr_sel;
   logic [PROD_W-1:0]   avg_scaled;
   logic                crossed;
   logic [OHMS_W-1:0]   ohms;
   logic [SUM_W:0]      sum_add;
   logic [2:0]          level_mask;

   assign ctrl     = iscd_microcode(pc_ff);
   assign req_ready = (ctrl.op == OP_WAIT);
   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign re_sq = re_ff * re_ff;
   assign im_sq = im_ff * im_ff;

   // Square root: two radicand bits per step, restoring
   assign srem_shift = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign srem_trial = {{(SREM_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
   assign sqrt_ge    = (srem_shift >= srem_trial);

   // Divider: one quotient bit per step, quotient shifts into num_ff
   assign drem_shift = {drem_ff, num_ff[NUM_W-1]};
   assign div_ge     = (drem_shift >= {1'b0, den_ff});

   always_comb begin
      case (ctrl.sel)
         LVL_STRONG: thr_sel = thr_strong_ff;
         LVL_MIDDLE: thr_sel = thr_middle_ff;
         default:    thr_sel = thr_weak_ff;
      endcase
   end

   // Compare mean*256 with baseline*ratio; mode 1 flags a drop, mode 0 a rise
   assign avg_scaled = {2'b00, avg_ff, 8'b0};
   assign crossed    = detect_mode_ff ? (avg_scaled <= prod_ff) : (avg_scaled >= prod_ff);

   // Point impedance; a zero magnitude gives zero ohms
   assign ohms    = (root_ff == '0) ? '0 : num_ff[OHMS_W-1:0];
   assign sum_add = {1'b0, sum_ff} + (SUM_W + 1)'(ohms);

   always_comb begin
      case (level_ff)
         LVL_WEAK:   level_mask = 3'b001;
         LVL_MIDDLE: level_mask = 3'b010;
         LVL_STRONG: level_mask = 3'b100;
         default:    level_mask = 3'b000;
      endcase
   end

   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:        cond_hit = 1'b0;
         COND_ALWAYS:      cond_hit = 1'b1;
         COND_NO_REQ:      cond_hit = !req_valid;
         COND_ITER_MORE:   cond_hit = (iter_ff != ITER_W'(1));
         COND_MAG_ZERO:    cond_hit = (root_ff == '0);
         COND_NOT_DONE:    cond_hit = !done_ff;
         COND_BASE_VALID:  cond_hit = base_valid_ff;
         COND_CROSSED:     cond_hit = crossed;
         COND_RSP_BLOCKED: cond_hit = !rsp_free;
         default:          cond_hit = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------
   // Next-state logic: one op per control word
   // ---------------------------------------------------------------
   always_comb begin
      pc_in         = cond_hit ? ctrl.target : pc_ff + PC_W'(1);
      iter_in       = iter_ff;
      re_in         = re_ff;
      im_in         = im_ff;
      done_in       = done_ff;
      sq_in         = sq_ff;
      rad_in        = rad_ff;
      srem_in       = srem_ff;
      root_in       = root_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      drem_in       = drem_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      avg_in        = avg_ff;
      prod_in       = prod_ff;
      level_in      = level_ff;
      captured_in   = captured_ff;
      baseline_in   = baseline_ff;
      base_valid_in = base_valid_ff;
      sticky_in     = sticky_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_flags_in  = rsp_flags_ff;
      rsp_capt_in   = rsp_capt_ff;
      // drop the response once the consumer takes it
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (ctrl.op)
         OP_WAIT: begin
            if (req_fire) begin
               re_in   = req_real_part;
               im_in   = req_imag_part;
               done_in = req_sweep_done;
            end
         end
         OP_SQ_RE: sq_in = SQ_W'($unsigned(re_sq));
         OP_SQ_IM: sq_in = sq_ff + SQ_W'($unsigned(im_sq));
         OP_SQRT_INIT: begin
            rad_in  = {sq_ff, 8'b0};
            srem_in = '0;
            root_in = '0;
            iter_in = SQRT_STEPS;
         end
         OP_SQRT_STEP: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            iter_in = iter_ff - ITER_W'(1);
            if (sqrt_ge) begin
               srem_in = srem_shift - srem_trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = srem_shift;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_DIV_OHMS_INIT: begin
            // left-align the 36-bit dividend scale*16
            num_in  = {scale_ff, 8'b0};
            den_in  = root_ff;
            drem_in = '0;
            iter_in = OHMS_STEPS;
         end
         OP_DIV_AVG_INIT: begin
            num_in  = sum_ff;
            den_in  = DEN_W'(count_ff);
            drem_in = '0;
            iter_in = AVG_STEPS;
         end
         OP_DIV_STEP: begin
            iter_in = iter_ff - ITER_W'(1);
            if (div_ge) begin
               drem_in = DEN_W'(drem_shift - {1'b0, den_ff});
               num_in  = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               drem_in = drem_shift[DEN_W-1:0];
               num_in  = {num_ff[NUM_W-2:0], 1'b0};
            end
         end
         OP_ACCUM: begin
            // past the point limit, hold sum and count
            if (count_ff < CNT_W'(MAX_POINTS)) begin
               sum_in   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_AVG_SAT: begin
            avg_in      = (|num_ff[NUM_W-1:AVG_W]) ? '1 : num_ff[AVG_W-1:0];
            level_in    = LVL_NONE;
            captured_in = 1'b0;
         end
         OP_CAPTURE: begin
            baseline_in   = avg_ff;
            base_valid_in = 1'b1;
            captured_in   = 1'b1;
         end
         OP_PROD: prod_in = baseline_ff * thr_sel;
         OP_CMP: begin
            if (crossed) begin
               level_in = ctrl.sel;
            end
         end
         OP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_level_in = level_ff;
               rsp_flags_in = sticky_ff | level_mask;
               rsp_capt_in  = captured_ff;
               sticky_in    = sticky_ff | level_mask;
               sum_in       = '0;
               count_in     = '0;
            end
         end
         OP_NOP: ;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_WAIT;
         sum_ff        <= '0;
         count_ff      <= '0;
         baseline_ff   <= '0;
         base_valid_ff <= 1'b0;
         sticky_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         baseline_ff   <= baseline_in;
         base_valid_ff <= base_valid_in;
         sticky_ff     <= sticky_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and working registers: no reset needed
   always_ff @(posedge clock) begin
      iter_ff     <= iter_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      done_ff     <= done_in;
      sq_ff       <= sq_in;
      rad_ff      <= rad_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      drem_ff     <= drem_in;
      avg_ff      <= avg_in;
      prod_ff     <= prod_in;
      level_ff    <= level_in;
      captured_ff <= captured_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_level_ff <= rsp_level_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_capt_ff <= rsp_capt_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_average_ohms      = rsp_avg_ff;
   assign rsp_change_level      = rsp_level_ff;
   assign rsp_level_flags       = rsp_flags_ff;
   assign rsp_baseline_captured = rsp_capt_ff;

endmodule

>>> rtl/iscd_checker.sv
// Port-level checker for the impedance sweep change detector, with its bind.
// Depends on iscd_pkg for the change-level codes.
module iscd_checker
   import iscd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_change_level,
   input logic [2:0]       rsp_level_flags,
   input logic             rsp_baseline_captured
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a reported change level other than none always has its sticky flag set
   a_level_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_change_level == LVL_NONE)
                 || (rsp_change_level == LVL_WEAK && rsp_level_flags[0])
                 || (rsp_change_level == LVL_MIDDLE && rsp_level_flags[1])
                 || (rsp_change_level == LVL_STRONG && rsp_level_flags[2]))
      else $error("change level without its sticky flag");

   // the baseline sweep reports no change
   a_capture_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_baseline_captured |-> rsp_change_level == LVL_NONE)
      else $error("baseline sweep reports a change level");

   // one request at a time: ready drops after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

endmodule

bind impedance_sweep_change_detector_unit iscd_checker u_iscd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_change_level      (rsp_change_level),
   .rsp_level_flags       (rsp_level_flags),
   .rsp_baseline_captured (rsp_baseline_captured)
);

>>> tb/sv/impedance_sweep_change_detector_unit_test.sv
// Self-checking testbench for impedance_sweep_change_detector_unit.
// Holds a sweep-average predictor class, the request and register drivers and the checker.
// Depends on iscd_pkg and the RTL of the unit; reads no files.
module impedance_sweep_change_detector_unit_test
   import iscd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD   = 10;
   localparam int          RESET_CYCLES   = 7;
   localparam int          POINT_LIMIT    = 512;
   localparam int          SETTLE_CYCLES  = 150;     // longer than one sweep-ending point
   localparam int          SQUEEZE_AFTER  = 30;      // summaries seen before the long hold-off
   localparam int          SQUEEZE_CYCLES = 3000;
   localparam longint      CYCLE_LIMIT    = 2_500_000;
   localparam logic [63:0] SUM_LIMIT      = (64'd1 << SUM_W) - 1;
   localparam logic [63:0] AVG_LIMIT      = (64'd1 << AVG_W) - 1;
   localparam logic [31:0] SCALE_DEFAULT  = 32'd208671300;

   typedef struct {
      logic [AVG_W-1:0] average_ohms;
      logic [1:0]       change_level;
      logic [2:0]       level_flags;
      logic             baseline_captured;
   } sweep_summary_type;

   // Predicts the per-sweep summaries and checks the ones the unit returns.
   class sweep_average_book;
      logic                 mode_drop;
      logic [SCALE_W-1:0]   scale;
      logic [THR_W-1:0]     ratio_strong;
      logic [THR_W-1:0]     ratio_middle;
      logic [THR_W-1:0]     ratio_weak;
      logic [SUM_W-1:0]     ohms_total;
      int unsigned          points_taken;
      logic [AVG_W-1:0]     baseline;
      logic                 baseline_held;
      logic [2:0]           flags;
      sweep_summary_type    summaries_due[$];
      int                   failures;
      int                   summaries_seen;

      function new();
         mode_drop      = 1'b1;
         scale          = SCALE_DEFAULT;
         ratio_strong   = 10'd128;
         ratio_middle   = 10'd166;
         ratio_weak     = 10'd205;
         ohms_total     = '0;
         points_taken   = 0;
         baseline       = '0;
         baseline_held  = 1'b0;
         flags          = '0;
         failures       = 0;
         summaries_seen = 0;
      endfunction

      function void set_register(logic [IDX_W-1:0] index, logic [CSR_W-1:0] value);
         case (index)
            CSR_DETECT_MODE:      mode_drop    = value[0];
            CSR_IMPEDANCE_SCALE:  scale        = value[SCALE_W-1:0];
            CSR_THRESHOLD_STRONG: ratio_strong = value[THR_W-1:0];
            CSR_THRESHOLD_MIDDLE: ratio_middle = value[THR_W-1:0];
            CSR_THRESHOLD_WEAK:   ratio_weak   = value[THR_W-1:0];
            default: ;
         endcase
      endfunction

      // floor(sqrt(n)), one result bit per pair of radicand bits
      function logic [63:0] root_floor(logic [63:0] n);
         logic [63:0] root;
         logic [63:0] probe;
         root  = '0;
         probe = 64'd1 << 62;
         while (probe > n)
            probe >>= 2;
         while (probe != 0) begin
            if (n >= root + probe) begin
               n    = n - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         return root;
      endfunction

      function bit crosses(logic [63:0] avg, logic [THR_W-1:0] ratio);
         logic [63:0] scaled_avg;
         logic [63:0] scaled_base;
         scaled_avg  = avg << 8;
         scaled_base = 64'(baseline) * 64'(ratio);
         return mode_drop ? (scaled_avg <= scaled_base) : (scaled_avg >= scaled_base);
      endfunction

      function void note_point(logic signed [15:0] re, logic signed [15:0] im, logic done);
         longint            power;
         logic [63:0]       mag_q4;
         logic [63:0]       ohms;
         logic [63:0]       total;
         logic [63:0]       avg;
         logic [1:0]        level;
         logic              captured;
         sweep_summary_type summary;
         power  = longint'(re) * longint'(re) + longint'(im) * longint'(im);
         mag_q4 = root_floor(64'(power) << 8);
         ohms   = (mag_q4 != 0) ? {28'd0, scale, 4'd0} / mag_q4 : 64'd0;
         if (points_taken < POINT_LIMIT) begin
            total        = 64'(ohms_total) + ohms;
            ohms_total   = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
            points_taken = points_taken + 1;
         end
         if (!done)
            return;
         avg = (points_taken != 0) ? 64'(ohms_total) / 64'(points_taken) : 64'd0;
         if (avg > AVG_LIMIT)
            avg = AVG_LIMIT;
         level    = LVL_NONE;
         captured = 1'b0;
         if (!baseline_held) begin
            baseline      = avg[AVG_W-1:0];
            baseline_held = 1'b1;
            captured      = 1'b1;
         end else if (crosses(avg, ratio_strong)) begin
            level = LVL_STRONG;
         end else if (crosses(avg, ratio_middle)) begin
            level = LVL_MIDDLE;
         end else if (crosses(avg, ratio_weak)) begin
            level = LVL_WEAK;
         end
         if (level != LVL_NONE)
            flags = flags | 3'(1 << (level - 2'd1));
         summary.average_ohms      = avg[AVG_W-1:0];
         summary.change_level      = level;
         summary.level_flags       = flags;
         summary.baseline_captured = captured;
         summaries_due.push_back(summary);
         ohms_total   = '0;
         points_taken = 0;
      endfunction

      function void check_summary(sweep_summary_type got);
         sweep_summary_type want;
         summaries_seen++;
         if (summaries_due.size() == 0) begin
            $error("unexpected sweep summary: average_ohms %0d", got.average_ohms);
            failures++;
            return;
         end
         want = summaries_due.pop_front();
         if (got.average_ohms !== want.average_ohms) begin
            $error("average_ohms: expected %0d, actual %0d", want.average_ohms, got.average_ohms);
            failures++;
         end
         if (got.change_level !== want.change_level) begin
            $error("change_level: expected %0d, actual %0d", want.change_level, got.change_level);
            failures++;
         end
         if (got.level_flags !== want.level_flags) begin
            $error("level_flags: expected %0d, actual %0d", want.level_flags, got.level_flags);
            failures++;
         end
         if (got.baseline_captured !== want.baseline_captured) begin
            $error("baseline_captured: expected %0d, actual %0d",
                   want.baseline_captured, got.baseline_captured);
            failures++;
         end
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic signed [15:0]  req_real_part  = '0;
   logic signed [15:0]  req_imag_part  = '0;
   logic                req_sweep_done = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [AVG_W-1:0]    rsp_average_ohms;
   logic [1:0]          rsp_change_level;
   logic [2:0]          rsp_level_flags;
   logic                rsp_baseline_captured;
   logic                csr_wr_en      = 1'b0;
   logic [IDX_W-1:0]    csr_index      = CSR_DETECT_MODE;
   logic [CSR_W-1:0]    csr_data       = '0;

   longint              cycle_count    = 0;
   int                  calm_left      = 0;
   sweep_average_book   sweeps         = new();

   impedance_sweep_change_detector_unit #(
      .MAX_POINTS(POINT_LIMIT)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_real_part         (req_real_part),
      .req_imag_part         (req_imag_part),
      .req_sweep_done        (req_sweep_done),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_average_ohms      (rsp_average_ohms),
      .rsp_change_level      (rsp_change_level),
      .rsp_level_flags       (rsp_level_flags),
      .rsp_baseline_captured (rsp_baseline_captured),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Check every summary at the edge that takes it; values are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sweeps.check_summary(sweep_summary_type'{rsp_average_ohms, rsp_change_level,
                                                  rsp_level_flags, rsp_baseline_captured});
   end

   // Result-side pacing: short stalls, a few long ones, long free-running stretches,
   // and once a long hold-off so the unit backs up and drops req_ready.
   initial begin : result_pacing
      int stall_left;
      int flow_left;
      bit squeezed;
      stall_left = 0;
      flow_left  = 0;
      squeezed   = 1'b0;
      forever begin
         @(posedge clock);
         if (!squeezed && sweeps.summaries_seen >= SQUEEZE_AFTER) begin
            squeezed = 1'b1;
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (flow_left > 0) begin
            flow_left--;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200)
                                                     : $urandom_range(1, 4);
         end else begin
            flow_left = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 800)
                                                    : $urandom_range(1, 20);
         end
      end
   end

   // Gap before the next request: mostly none, some short, a few long,
   // with occasional calm stretches of back-to-back requests.
   function automatic int pick_gap();
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5)
         calm_left = $urandom_range(20, 80);
      if (roll < 60)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // Data word biased toward zero, the extremes and tiny magnitudes.
   function automatic int noise_word();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return -32768;
         2:       return 32767;
         3:       return int'($urandom_range(0, 6)) - 3;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Offer one sweep point, hold it until taken, then log it with the predictor.
   task automatic send_point(int re, int im, bit done);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_real_part  <= 16'(re);
      req_imag_part  <= 16'(im);
      req_sweep_done <= done;
      do
         @(posedge clock);
      while (!req_ready);
      sweeps.note_point(16'(re), 16'(im), done);
   endtask

   // Drop valid, wait out every pending summary, then let a trailing point finish.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (sweeps.summaries_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [IDX_W-1:0] index, logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      sweeps.set_register(index, value);
   endtask

   task automatic apply_settings(bit mode, logic [31:0] scale, int strong_ratio,
                                 int middle_ratio, int weak_ratio);
      write_register(CSR_DETECT_MODE, CSR_W'(mode));
      write_register(CSR_IMPEDANCE_SCALE, scale);
      write_register(CSR_THRESHOLD_STRONG, CSR_W'(strong_ratio));
      write_register(CSR_THRESHOLD_MIDDLE, CSR_W'(middle_ratio));
      write_register(CSR_THRESHOLD_WEAK, CSR_W'(weak_ratio));
      csr_wr_en <= 1'b0;
   endtask

   // Random sweeps. Most are well formed: every point sits near one magnitude,
   // picked so the mean lands somewhere between 0.1x and 4x the baseline.
   // The rest are noise sweeps with extreme, zero and tiny words.
   task automatic run_sweeps(int budget);
      int     len;
      int     style;
      int     m;
      int     re;
      int     im;
      int     jitter;
      longint target;
      while (budget > 0) begin
         len    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         style  = $urandom_range(0, 9);
         target = longint'(sweeps.baseline) * $urandom_range(10, 400) / 100;
         m      = (target > 0) ? int'(longint'(sweeps.scale) / target) : $urandom_range(1, 23000);
         if (m < 1)
            m = 1;
         if (m > 23000)
            m = 23000;
         jitter = m / 40;
         for (int k = 0; k < len; k++) begin
            if (style < 7) begin
               re = int'($urandom_range(0, 2 * m)) - m;
               im = int'(sweeps.root_floor(64'(longint'(m) * m - longint'(re) * re)));
               if ($urandom_range(0, 1) == 1)
                  im = -im;
               re = re + int'($urandom_range(0, 2 * jitter)) - jitter;
               im = im + int'($urandom_range(0, 2 * jitter)) - jitter;
               // sprinkle dead points into some sweeps
               if (style == 6 && $urandom_range(0, 2) == 0) begin
                  re = 0;
                  im = 0;
               end
            end else begin
               re = noise_word();
               im = noise_word();
            end
            send_point(re, im, k == len - 1);
            budget--;
         end
      end
   endtask

   task automatic run_phase(bit mode, logic [31:0] scale, int strong_ratio, int middle_ratio,
                            int weak_ratio, int budget);
      drain_block();
      apply_settings(mode, scale, strong_ratio, middle_ratio, weak_ratio);
      run_sweeps(budget);
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings (drop mode, ratios 0.5 / 0.65 / 0.8).
      // Baseline sweep: three points of magnitude 1000.
      send_point(600, 800, 1'b0);
      send_point(-800, 600, 1'b0);
      send_point(600, -800, 1'b1);
      // Extreme words, a zero-magnitude point, and a unit point that dominates the mean.
      send_point(-32768, -32768, 1'b0);
      send_point(32767, 32767, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(-32768, 32767, 1'b0);
      send_point(1, -1, 1'b1);
      // A single dead point: mean of zero.
      send_point(0, 0, 1'b1);
      // Means near 0.6x and 0.75x of the baseline.
      send_point(1000, 1333, 1'b1);
      send_point(800, 1066, 1'b1);
      // Extremes on one axis only.
      send_point(0, -32768, 1'b0);
      send_point(32767, 0, 1'b0);
      send_point(-32768, 0, 1'b0);
      send_point(-1, 0, 1'b1);

      // Random phases; each rewrites every register once the unit is idle.
      run_phase(1'b0, SCALE_DEFAULT, 512, 384, 320, 90);
      run_phase(1'b1, SCALE_DEFAULT, 128, 166, 205, 90);
      run_phase(1'b1, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), 90);
      run_phase(1'b0, SCALE_DEFAULT, 1023, 1023, 0, 90);
      run_phase(1'b1, SCALE_DEFAULT, 0, 0, 1023, 90);
      run_phase(1'($urandom_range(0, 1)), 32'd0, $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023), 60);
      run_phase(1'($urandom_range(0, 1)), 32'hFFFF_FFFF, 128, 166, 205, 90);
      run_phase(1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023), 90);

      // One overlong sweep at full scale with tiny words: saturate the sum,
      // run past the point limit, then check the next sweeps start clean.
      drain_block();
      apply_settings(1'($urandom_range(0, 1)), 32'hFFFF_FFFF, 128, 166, 205);
      for (int k = 0; k < POINT_LIMIT + 8; k++)
         send_point(int'($urandom_range(0, 4)) - 2, int'($urandom_range(0, 4)) - 2,
                    k == POINT_LIMIT + 7);
      run_sweeps(40);

      drain_block();
      if (sweeps.failures == 0 && sweeps.summaries_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> impedance_sweep_change_detector_unit.f
rtl/iscd_pkg.sv
rtl/impedance_sweep_change_detector_unit.sv
rtl/iscd_checker.sv
tb/sv/impedance_sweep_change_detector_unit_test.sv
